// ----- hdl/cip_pkg.sv -----
package cip_pkg;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_COUNT = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;
  localparam logic [1:0] CMD_END   = 2'd3;

  localparam int unsigned CH_BITS = 8;

  typedef struct packed {
    logic [1:0]         command;
    logic [CH_BITS-1:0] channel;
    logic [31:0]        now_ticks;
  } in_item_t;

  typedef struct packed {
    logic [31:0] elapsed;
    logic [31:0] event_count;
    logic [31:0] total_ticks;
    logic        running;
    logic        channel_ok;
  } out_item_t;

  // per-channel record, kept whole in one ram word
  typedef struct packed {
    logic [31:0] event_count;
    logic [31:0] total_ticks;
    logic [31:0] start_stamp;
    logic        running;
  } chan_rec_t;

  localparam int unsigned STORE_W = $bits(chan_rec_t);

endpackage

// ----- hdl/cip_ram.sv -----
module cip_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/cip_update.sv -----
module cip_update import cip_pkg::*; (
  input  in_item_t  item,
  input  logic      in_range,
  input  chan_rec_t cur,
  output chan_rec_t nxt,
  output out_item_t res
);

  logic [31:0] delta;
  logic        ok;
  logic [31:0] elapsed;

  assign delta = item.now_ticks - cur.start_stamp;

  always_comb begin
    nxt     = cur;
    ok      = 1'b1;
    elapsed = '0;
    case (item.command)
      CMD_CLEAR: begin
        nxt = '0;
      end
      CMD_COUNT: begin
        nxt.event_count = cur.event_count + 32'd1;
      end
      CMD_START: begin
        nxt.start_stamp = item.now_ticks;
        nxt.running     = 1'b1;
      end
      CMD_END: begin
        if (cur.running) begin
          elapsed         = delta;
          nxt.total_ticks = cur.total_ticks + delta;
          nxt.event_count = cur.event_count + 32'd1;
          nxt.running     = 1'b0;
        end else begin
          ok = 1'b0;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  always_comb begin
    if (in_range) begin
      res.elapsed     = elapsed;
      res.event_count = nxt.event_count;
      res.total_ticks = nxt.total_ticks;
      res.running     = nxt.running;
      res.channel_ok  = ok;
    end else begin
      res = '0;
    end
  end

endmodule

// ----- hdl/channel_interval_profiler.sv -----
// channel   | ports                        | handshake
// ----------+------------------------------+-----------------------------------
// request   | start, busy, in_item         | taken when start & !busy
// result    | out_valid, out_result        | one-cycle strobe, no back-pressure
//
// one result per request, registered through the ram read stage and then the
// update and result register; a request may come every cycle.
// busy stays low: the latest ram write is forwarded to a read of the same
// channel that follows right behind it.
// reset (rst_n, synchronous) clears the channel valid bits, so every channel
// reads as zero with no clearing pass.
module channel_interval_profiler import cip_pkg::*; #(
  parameter int unsigned CHANNELS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_result
);

  localparam int unsigned AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned DEPTH = 1 << AW;
  localparam logic [CH_BITS:0] CH_LIMIT = (CH_BITS+1)'(CHANNELS);

  logic               accept;
  logic               s1_valid_r;
  in_item_t           s1_item_r;
  logic [AW-1:0]      s1_addr;
  logic               s1_in_range;
  logic [STORE_W-1:0] ram_rdata;
  logic [STORE_W-1:0] store_cur;
  logic               wr_en;
  logic [DEPTH-1:0]   entry_valid_r;
  logic               fwd_valid_r;
  logic [AW-1:0]      fwd_addr_r;
  logic [STORE_W-1:0] fwd_data_r;
  chan_rec_t          cur_rec;
  chan_rec_t          nxt_rec;
  out_item_t          res;
  logic [STORE_W-1:0] wr_data;
  logic               out_valid_r;
  out_item_t          out_result_r;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
    if (accept) begin
      s1_item_r <= in_item;
    end
  end

  assign s1_addr     = s1_item_r.channel[AW-1:0];
  assign s1_in_range = {1'b0, s1_item_r.channel} < CH_LIMIT;
  assign wr_en       = s1_valid_r & s1_in_range;
  assign wr_data     = nxt_rec;

  cip_ram #(
    .WIDTH (STORE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr),
    .wdata (wr_data),
    .raddr (in_item.channel[AW-1:0]),
    .rdata (ram_rdata)
  );

  // newest write wins over the ram, never-written entries read as zero
  always_comb begin
    if (fwd_valid_r && fwd_addr_r == s1_addr) begin
      store_cur = fwd_data_r;
    end else if (entry_valid_r[s1_addr]) begin
      store_cur = ram_rdata;
    end else begin
      store_cur = '0;
    end
    cur_rec = chan_rec_t'(store_cur);
  end

  cip_update u_update (
    .item     (s1_item_r),
    .in_range (s1_in_range),
    .cur      (cur_rec),
    .nxt      (nxt_rec),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= '0;
      fwd_valid_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
      if (wr_en) begin
        entry_valid_r[s1_addr] <= 1'b1;
        fwd_valid_r            <= 1'b1;
      end
    end
    if (wr_en) begin
      fwd_addr_r <= s1_addr;
      fwd_data_r <= wr_data;
    end
    if (s1_valid_r) begin
      out_result_r <= res;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

// ----- hdl/cip_checker.sv -----
module cip_sva import cip_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item,
  input logic      out_valid,
  input out_item_t out_result
);

  // every request gives exactly one result
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("request without result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> ##1 !out_valid)
    else $error("result without request");

  a_fail_no_delta: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_result.channel_ok) |-> out_result.elapsed == 32'd0)
    else $error("elapsed set on a rejected request");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.channel_ok && $past(in_item.command, 2) == CMD_CLEAR)
    |-> (out_result.event_count == 32'd0 && out_result.total_ticks == 32'd0
         && !out_result.running))
    else $error("clear left channel state");

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.channel_ok && $past(in_item.command, 2) == CMD_START)
    |-> (out_result.running && out_result.elapsed == 32'd0))
    else $error("start did not set running");

endmodule

bind channel_interval_profiler cip_sva u_cip_sva (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_item    (in_item),
  .out_valid  (out_valid),
  .out_result (out_result)
);
